// File: sv/isfm_pkg.sv
// ----------------------------------------------------------------------------
// isfm_pkg
// Shared sizes, operation codes, status codes and the command/status bundles
// passed between the stack controller and its datapath.
// ----------------------------------------------------------------------------
package isfm_pkg;

    localparam int INT_DEPTH    = 64;
    localparam int MARKER_DEPTH = 16;

    localparam int VAL_W     = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int INT_CNT_W = $clog2(INT_DEPTH + 1);
    localparam int INT_IDX_W = $clog2(INT_DEPTH);
    localparam int MK_CNT_W  = $clog2(MARKER_DEPTH + 1);
    localparam int MK_IDX_W  = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_FIELD_W = VAL_W + STAT_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_INT  = 3'd0,
        FN_PUSH_MARK = 3'd1,
        FN_POP_INT   = 3'd2,
        FN_PEEK_INT  = 3'd3,
        FN_PEEK_ELEM = 3'd4,
        FN_POP_ELEM  = 3'd5,
        FN_CLEAR     = 3'd6
    } func_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;

    typedef struct packed {
        logic take;
        logic top;
        logic run;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic in_deferred;
        logic elem_op;
        logic mark_empty;
        logic run_empty;
        logic run_last;
    } stat_t;

endpackage

// File: sv/isfm_ram.sv
// ----------------------------------------------------------------------------
// isfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/isfm_ctrl.sv
// ----------------------------------------------------------------------------
// isfm_ctrl
// Sequencer: takes one operation, waits for stack reads on pops and peeks, then walks a run for element reads.
// ----------------------------------------------------------------------------
module isfm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  isfm_pkg::stat_t stat,
    output isfm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TOP  = 3'b010,
        S_RUN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = stat.slot_free;
                if (s_tvalid && stat.slot_free)
                begin
                    cmd.take = 1'b1;
                    if (stat.in_deferred)
                    begin
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP:
            begin
                if (stat.slot_free)
                begin
                    cmd.top = 1'b1;
                    if (stat.elem_op && !stat.mark_empty && !stat.run_empty)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RUN:
            begin
                if (stat.slot_free)
                begin
                    cmd.run = 1'b1;
                    if (stat.run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/isfm_dp.sv
// ----------------------------------------------------------------------------
// isfm_dp
// Stack datapath: int and marker memories, depth counters, run walker and
// the output beat register.
// ----------------------------------------------------------------------------
module isfm_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [isfm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic [isfm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    input  isfm_pkg::cmd_t                   cmd,
    output isfm_pkg::stat_t                  stat,
    output logic                             m_tvalid,
    output logic [isfm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [isfm_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);

    localparam int ICW = isfm_pkg::INT_CNT_W;
    localparam int IIW = isfm_pkg::INT_IDX_W;
    localparam int MCW = isfm_pkg::MK_CNT_W;
    localparam int MIW = isfm_pkg::MK_IDX_W;
    localparam int VW  = isfm_pkg::VAL_W;
    localparam int SW  = isfm_pkg::STAT_W;

    logic [ICW-1:0]       icount_reg, icount_next;
    logic [MCW-1:0]       mcount_reg, mcount_next;
    isfm_pkg::func_t      func_reg, func_next;
    logic [IIW-1:0]       idx_reg, idx_next;
    logic [ICW-1:0]       top_reg, top_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_value_reg;
    logic [SW-1:0]        out_status_reg;
    logic                 out_hv_reg;
    logic                 out_last_reg;
    logic                 out_empty_reg;

    logic                 emit;
    logic signed [VW-1:0] e_value;
    logic [SW-1:0]        e_status;
    logic                 e_hv;
    logic                 e_last;

    logic                 iw_en, ir_en, mw_en, mr_en;
    logic [IIW-1:0]       iw_addr, ir_addr;
    logic [VW-1:0]        iw_data, ir_data;
    logic [MIW-1:0]       mw_addr, mr_addr;
    logic [ICW-1:0]       mw_data, mr_data;

    isfm_pkg::func_t      in_func;
    logic [ICW-1:0]       icount_dec;
    logic [MCW-1:0]       mcount_dec;
    logic                 int_empty, int_full, mark_empty, mark_full;
    logic                 run_empty, run_last;
    logic [IIW-1:0]       int_top_addr, idx_inc;
    logic [MIW-1:0]       mk_top_addr;

    isfm_ram #(
        .WIDTH (VW),
        .DEPTH (isfm_pkg::INT_DEPTH)
    ) u_int_ram (
        .clk     (clk),
        .wr_en   (iw_en),
        .wr_addr (iw_addr),
        .wr_data (iw_data),
        .rd_en   (ir_en),
        .rd_addr (ir_addr),
        .rd_data (ir_data)
    );

    isfm_ram #(
        .WIDTH (ICW),
        .DEPTH (isfm_pkg::MARKER_DEPTH)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mw_en),
        .wr_addr (mw_addr),
        .wr_data (mw_data),
        .rd_en   (mr_en),
        .rd_addr (mr_addr),
        .rd_data (mr_data)
    );

    assign in_func      = isfm_pkg::func_t'(s_tuser);
    assign icount_dec   = icount_reg - ICW'(1);
    assign mcount_dec   = mcount_reg - MCW'(1);
    assign int_empty    = (icount_reg == '0);
    assign mark_empty   = (mcount_reg == '0);
    assign int_full     = (icount_reg >= ICW'(isfm_pkg::INT_DEPTH));
    assign mark_full    = (mcount_reg >= MCW'(isfm_pkg::MARKER_DEPTH));
    assign int_top_addr = int_empty ? '0 : icount_dec[IIW-1:0];
    assign mk_top_addr  = mark_empty ? '0 : mcount_dec[MIW-1:0];
    assign run_empty    = (mr_data >= icount_reg);
    assign run_last     = ((ICW'(idx_reg) + ICW'(1)) == top_reg);
    assign idx_inc      = idx_reg + IIW'(1);

    assign stat.slot_free   = !out_valid_reg || m_tready;
    assign stat.in_deferred = (in_func == isfm_pkg::FN_POP_INT)
                           || (in_func == isfm_pkg::FN_PEEK_INT)
                           || (in_func == isfm_pkg::FN_PEEK_ELEM)
                           || (in_func == isfm_pkg::FN_POP_ELEM);
    assign stat.elem_op     = (func_reg == isfm_pkg::FN_PEEK_ELEM)
                           || (func_reg == isfm_pkg::FN_POP_ELEM);
    assign stat.mark_empty  = mark_empty;
    assign stat.run_empty   = run_empty;
    assign stat.run_last    = run_last;

    always_comb
    begin
        icount_next = icount_reg;
        mcount_next = mcount_reg;
        func_next   = func_reg;
        idx_next    = idx_reg;
        top_next    = top_reg;
        emit        = 1'b0;
        e_value     = '0;
        e_status    = isfm_pkg::STAT_OK;
        e_hv        = 1'b0;
        e_last      = 1'b1;
        iw_en       = 1'b0;
        iw_addr     = icount_reg[IIW-1:0];
        iw_data     = s_tdata[VW-1:0];
        mw_en       = 1'b0;
        mw_addr     = mcount_reg[MIW-1:0];
        mw_data     = icount_reg;
        ir_en       = 1'b0;
        ir_addr     = int_top_addr;
        mr_en       = 1'b0;
        mr_addr     = mk_top_addr;

        if (cmd.take)
        begin
            func_next = in_func;
            case (in_func)
                isfm_pkg::FN_PUSH_INT:
                begin
                    emit = 1'b1;
                    if (int_full)
                    begin
                        e_status = isfm_pkg::STAT_OVER;
                    end
                    else
                    begin
                        iw_en       = 1'b1;
                        icount_next = icount_reg + ICW'(1);
                    end
                end
                isfm_pkg::FN_PUSH_MARK:
                begin
                    emit = 1'b1;
                    if (mark_full)
                    begin
                        e_status = isfm_pkg::STAT_OVER;
                    end
                    else
                    begin
                        mw_en       = 1'b1;
                        mcount_next = mcount_reg + MCW'(1);
                    end
                end
                isfm_pkg::FN_POP_INT, isfm_pkg::FN_PEEK_INT:
                begin
                    ir_en = 1'b1;
                    mr_en = 1'b1;
                end
                isfm_pkg::FN_PEEK_ELEM, isfm_pkg::FN_POP_ELEM:
                begin
                    mr_en = 1'b1;
                end
                isfm_pkg::FN_CLEAR:
                begin
                    emit        = 1'b1;
                    icount_next = '0;
                    mcount_next = '0;
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase
        end
        else if (cmd.top)
        begin
            case (func_reg)
                isfm_pkg::FN_POP_INT:
                begin
                    emit = 1'b1;
                    if (int_empty)
                    begin
                        e_status = isfm_pkg::STAT_UNDER;
                    end
                    else
                    begin
                        e_value     = ir_data;
                        e_hv        = 1'b1;
                        icount_next = icount_dec;
                        if (!mark_empty && (mr_data >= icount_dec))
                        begin
                            mcount_next = mcount_dec;
                        end
                    end
                end
                isfm_pkg::FN_PEEK_INT:
                begin
                    emit = 1'b1;
                    if (int_empty)
                    begin
                        e_status = isfm_pkg::STAT_UNDER;
                    end
                    else
                    begin
                        e_value = ir_data;
                        e_hv    = 1'b1;
                    end
                end
                isfm_pkg::FN_PEEK_ELEM, isfm_pkg::FN_POP_ELEM:
                begin
                    if (mark_empty)
                    begin
                        emit     = 1'b1;
                        e_status = isfm_pkg::STAT_UNDER;
                    end
                    else
                    begin
                        if (func_reg == isfm_pkg::FN_POP_ELEM)
                        begin
                            mcount_next = mcount_dec;
                        end
                        if (run_empty)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            idx_next = mr_data[IIW-1:0];
                            top_next = icount_reg;
                            ir_en    = 1'b1;
                            ir_addr  = mr_data[IIW-1:0];
                            if (func_reg == isfm_pkg::FN_POP_ELEM)
                            begin
                                icount_next = mr_data;
                            end
                        end
                    end
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase
        end
        else if (cmd.run)
        begin
            emit    = 1'b1;
            e_value = ir_data;
            e_hv    = 1'b1;
            e_last  = run_last;
            if (!run_last)
            begin
                idx_next = idx_inc;
                ir_en    = 1'b1;
                ir_addr  = idx_inc;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icount_reg    <= '0;
            mcount_reg    <= '0;
            func_reg      <= isfm_pkg::FN_PUSH_INT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            icount_reg    <= icount_next;
            mcount_reg    <= mcount_next;
            func_reg      <= func_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        top_reg <= top_next;
        if (emit)
        begin
            out_value_reg  <= e_value;
            out_status_reg <= e_status;
            out_hv_reg     <= e_hv;
            out_last_reg   <= e_last;
            out_empty_reg  <= (icount_next == '0) && (mcount_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{isfm_pkg::M_PAD_W{1'b0}}, out_empty_reg, out_status_reg,
                       out_value_reg};
    assign m_tuser  = out_hv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/int_stack_with_frame_markers_unit.sv
// ----------------------------------------------------------------------------
// int_stack_with_frame_markers_unit
// Operand stack of 32-bit ints with a stack of frame markers; element reads
// stream the ints above the top marker as a run closed by tlast.
//
//   channel  dir  tdata                                    tuser      tlast
//   s_*      in   [31:0] value                             [2:0] func  -
//   m_*      out  [31:0] value_res [33:32] status          [0] has_    last
//                 [34] stack_empty [39:35] zero                 value
//
// Push int, push marker, clear and unused codes: a result beat, with no wait state.
// Pop int, peek int: the result waits for the registered read of the stack RAMs.
// Peek/pop element: marker read, int read, then one beat per cycle per int unless stalled.
// Reset clears both depth counters; stack RAM contents need no clearing.
// A stalled output beat holds the sequencer; no input is taken during a run.
// ----------------------------------------------------------------------------
module int_stack_with_frame_markers_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [isfm_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [isfm_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [isfm_pkg::M_TDATA_W-1:0] m_tdata,  // value_res, status, stack_empty
    output logic [isfm_pkg::M_TUSER_W-1:0] m_tuser,  // [0] has_value
    output logic                           m_tlast
);

    isfm_pkg::cmd_t  cmd;
    isfm_pkg::stat_t stat;

    isfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    isfm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_take_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |-> !s_tready)
        else $error("input taken during a run");

    a_run_beat_has_value: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |=> (m_tvalid && m_tuser[0]))
        else $error("run beat without a stack entry");

    a_error_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[33:32] != isfm_pkg::STAT_OK)) |-> (!m_tuser[0] && m_tlast))
        else $error("error beat carries a value or is not last");

endmodule

// File: dv/int_stack_with_frame_markers_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_stack_with_frame_markers_unit_tb
// Self-checking bench for the int stack with frame markers. A generator
// queues directed and random stack operations. A driver offers them on the
// input stream with random gaps, and a receiver takes results with random
// stalls plus one long hold-off. Each accepted operation runs through a
// behavioral stack model whose predicted beats are checked in order against
// the output stream.
// ----------------------------------------------------------------------------
module int_stack_with_frame_markers_unit_tb;
    import isfm_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [VAL_W-1:0]  val;
        int                gap;
    } stack_op_t;

    typedef struct {
        logic [VAL_W-1:0]  value_res;
        logic [STAT_W-1:0] status;
        logic              has_value;
        logic              is_last;
        logic              stack_empty;
    } stack_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    stack_op_t   ops_to_send[$];
    stack_beat_t want_beats[$];

    logic [VAL_W-1:0] int_mem[INT_DEPTH];
    int               int_cnt = 0;
    int               mark_mem[MARKER_DEPTH];
    int               mark_cnt = 0;

    stack_op_t cur_op;
    bit        have_op = 1'b0;
    int        gap_left = 0;
    int        tx_calm_left = 0;
    int        rx_wait = 0;
    int        rx_calm_left = 0;
    logic      in_beat = 1'b0;
    logic      out_beat = 1'b0;
    logic      long_hold = 1'b0;

    int n_ops = 0;
    int n_taken = 0;
    int n_beats = 0;
    int n_under = 0;
    int n_over = 0;
    int longest_run = 0;
    int err_cnt = 0;
    int cycles = 0;
    bit int_fill_done = 1'b0;
    bit mark_fill_done = 1'b0;

    int_stack_with_frame_markers_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [M_TDATA_W-1:0] got,
                                   input logic [M_TDATA_W-1:0] want);
        $display("[%0t] beat %0d %s: got %h want %h", $time, n_beats, what, got, want);
        err_cnt++;
    endtask

    task automatic add_op(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val);
        stack_op_t op;
        op.fn  = fn;
        op.val = val;
        if (tx_calm_left > 0)
        begin
            op.gap = 0;
            tx_calm_left--;
        end
        else
        begin
            op.gap = $urandom_range(0, 9);
            if ($urandom_range(0, 24) == 0)
                tx_calm_left = $urandom_range(10, 30);
        end
        ops_to_send = {ops_to_send, op};
    endtask

    task automatic queue_result(input logic [VAL_W-1:0] res, input logic [STAT_W-1:0] st,
                                input logic hv, input logic lst);
        stack_beat_t b;
        b.value_res   = res;
        b.status      = st;
        b.has_value   = hv;
        b.is_last     = lst;
        b.stack_empty = (int_cnt == 0 && mark_cnt == 0);
        if (st == STAT_UNDER)
            n_under++;
        if (st == STAT_OVER)
            n_over++;
        want_beats = {want_beats, b};
    endtask

    task automatic apply_stack_op(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val);
        logic [VAL_W-1:0]  res;
        logic [STAT_W-1:0] st;
        logic              hv;
        int                start;
        int                top;
        res = '0;
        st  = STAT_OK;
        hv  = 1'b0;
        case (fn)
            FN_PUSH_INT:
                if (int_cnt >= INT_DEPTH)
                    st = STAT_OVER;
                else
                begin
                    int_mem[int_cnt] = val;
                    int_cnt++;
                end
            FN_PUSH_MARK:
                if (mark_cnt >= MARKER_DEPTH)
                    st = STAT_OVER;
                else
                begin
                    mark_mem[mark_cnt] = int_cnt;
                    mark_cnt++;
                end
            FN_POP_INT:
                if (int_cnt == 0)
                    st = STAT_UNDER;
                else
                begin
                    int_cnt--;
                    res = int_mem[int_cnt];
                    hv  = 1'b1;
                    if (mark_cnt > 0 && mark_mem[mark_cnt-1] >= int_cnt)
                        mark_cnt--;
                end
            FN_PEEK_INT:
                if (int_cnt == 0)
                    st = STAT_UNDER;
                else
                begin
                    res = int_mem[int_cnt-1];
                    hv  = 1'b1;
                end
            FN_PEEK_ELEM, FN_POP_ELEM:
                if (mark_cnt == 0)
                    st = STAT_UNDER;
                else
                begin
                    start = mark_mem[mark_cnt-1];
                    if (fn == FN_POP_ELEM)
                        mark_cnt--;
                    if (start >= int_cnt)
                    begin
                        queue_result('0, STAT_OK, 1'b0, 1'b1);
                        return;
                    end
                    top = int_cnt;
                    if (fn == FN_POP_ELEM)
                        int_cnt = start;
                    if (top - start > longest_run)
                        longest_run = top - start;
                    for (int i = start; i < top; i++)
                        queue_result(int_mem[i], STAT_OK, 1'b1, i + 1 == top);
                    return;
                end
            FN_CLEAR:
            begin
                int_cnt  = 0;
                mark_cnt = 0;
            end
            default:
                ;
        endcase
        queue_result(res, st, hv, 1'b1);
    endtask

    // drive the input stream
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_beat)
                have_op = 1'b0;
            if (!have_op && ops_to_send.size() > 0)
            begin
                cur_op   = ops_to_send.pop_front();
                have_op  = 1'b1;
                gap_left = cur_op.gap;
            end
            if (have_op && gap_left == 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= cur_op.val;
                s_tuser  <= cur_op.fn;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (have_op)
                    gap_left--;
            end
        end
    end

    // drive the output ready with random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_beat)
            begin
                if (rx_calm_left > 0)
                begin
                    rx_wait = 0;
                    rx_calm_left--;
                end
                else
                begin
                    rx_wait = $urandom_range(0, 9);
                    if ($urandom_range(0, 29) == 0)
                        rx_calm_left = $urandom_range(10, 40);
                end
            end
            if (long_hold)
                m_tready <= 1'b0;
            else if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // predict accepted operations and check output beats
    always @(posedge clk)
    begin : mon
        stack_beat_t w;
        in_beat  <= rst_n && s_tvalid && s_tready;
        out_beat <= rst_n && m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            apply_stack_op(s_tuser, s_tdata);
            n_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_beats.size() == 0)
                report_mismatch("beat with nothing expected", m_tdata, '0);
            else
            begin
                w = want_beats.pop_front();
                if (m_tdata[VAL_W-1:0] !== w.value_res)
                    report_mismatch("value_res", M_TDATA_W'(m_tdata[VAL_W-1:0]),
                                    M_TDATA_W'(w.value_res));
                if (m_tdata[VAL_W+STAT_W-1:VAL_W] !== w.status)
                    report_mismatch("status", M_TDATA_W'(m_tdata[VAL_W+STAT_W-1:VAL_W]),
                                    M_TDATA_W'(w.status));
                if (m_tdata[VAL_W+STAT_W] !== w.stack_empty)
                    report_mismatch("stack_empty", M_TDATA_W'(m_tdata[VAL_W+STAT_W]),
                                    M_TDATA_W'(w.stack_empty));
                if (m_tdata[M_TDATA_W-1:M_FIELD_W] !== '0)
                    report_mismatch("pad bits", M_TDATA_W'(m_tdata[M_TDATA_W-1:M_FIELD_W]),
                                    '0);
                if (m_tuser[0] !== w.has_value)
                    report_mismatch("has_value", M_TDATA_W'(m_tuser[0]),
                                    M_TDATA_W'(w.has_value));
                if (m_tlast !== w.is_last)
                    report_mismatch("tlast", M_TDATA_W'(m_tlast), M_TDATA_W'(w.is_last));
            end
            n_beats++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, want_beats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold off the receiver long enough for the block to back up
    initial
    begin
        while (n_taken < 60)
            @(negedge clk);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : stim
        int n_rand;
        int k;
        // empty stack errors and the unused code
        add_op(FN_POP_INT, '0);
        add_op(FN_PEEK_INT, '0);
        add_op(FN_PEEK_ELEM, '0);
        add_op(FN_POP_ELEM, '0);
        add_op(FN_SPARE, 32'hFFFF_FFFF);
        // one frame with extreme values
        add_op(FN_PUSH_MARK, '0);
        add_op(FN_PUSH_INT, 32'h8000_0000);
        add_op(FN_PUSH_INT, 32'h7FFF_FFFF);
        add_op(FN_PUSH_INT, 32'h0000_0000);
        add_op(FN_PUSH_INT, 32'hFFFF_FFFF);
        add_op(FN_PEEK_ELEM, '0);
        add_op(FN_PEEK_INT, '0);
        // marker drop on pop int, then a marker at depth gives an empty run
        add_op(FN_PUSH_MARK, '0);
        add_op(FN_PUSH_MARK, '0);
        add_op(FN_PUSH_INT, 32'h5A5A_5A5A);
        add_op(FN_POP_INT, '0);
        add_op(FN_PEEK_ELEM, '0);
        add_op(FN_POP_ELEM, '0);
        // marker above the int depth
        add_op(FN_PUSH_MARK, '0);
        add_op(FN_PUSH_MARK, '0);
        add_op(FN_POP_INT, '0);
        add_op(FN_PEEK_ELEM, '0);
        add_op(FN_POP_ELEM, '0);
        add_op(FN_POP_ELEM, '0);
        add_op(FN_CLEAR, '0);

        n_rand = 0;
        while (n_rand < 250 || !int_fill_done || !mark_fill_done)
        begin
            k = ops_to_send.size();
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    add_op(FN_PUSH_MARK, $urandom);
                    repeat ($urandom_range(0, 7))
                        add_op(FN_PUSH_INT, $urandom);
                    if ($urandom_range(0, 1) == 0)
                        add_op(FN_PEEK_INT, $urandom);
                    if ($urandom_range(0, 1) == 0)
                        add_op(FN_PEEK_ELEM, $urandom);
                    if ($urandom_range(0, 2) == 0)
                        add_op(FN_POP_INT, $urandom);
                    if ($urandom_range(0, 9) < 7)
                        add_op(FN_POP_ELEM, $urandom);
                end
                7, 8, 9, 10:
                    add_op(FUNC_W'($urandom_range(0, 7)), $urandom);
                11:
                begin
                    add_op(FN_PUSH_MARK, $urandom);
                    repeat ($urandom_range(0, 4))
                        add_op(FN_PUSH_INT, $urandom);
                    add_op(FN_PUSH_MARK, $urandom);
                    repeat ($urandom_range(0, 4))
                        add_op(FN_PUSH_INT, $urandom);
                    add_op(FN_POP_ELEM, $urandom);
                    add_op(FN_POP_ELEM, $urandom);
                end
                12:
                    add_op(FN_CLEAR, $urandom);
                13:
                    if (!int_fill_done || n_rand >= 250)
                    begin
                        add_op(FN_CLEAR, $urandom);
                        add_op(FN_PUSH_MARK, $urandom);
                        repeat (INT_DEPTH + 1)
                            add_op(FN_PUSH_INT, $urandom);
                        add_op(FN_PEEK_ELEM, $urandom);
                        add_op(FN_POP_ELEM, $urandom);
                        int_fill_done = 1'b1;
                    end
                14:
                    if (!mark_fill_done || n_rand >= 250)
                    begin
                        repeat (MARKER_DEPTH + 1)
                            add_op(FN_PUSH_MARK, $urandom);
                        add_op(FN_PEEK_ELEM, $urandom);
                        add_op(FN_CLEAR, $urandom);
                        mark_fill_done = 1'b1;
                    end
                default:
                    repeat ($urandom_range(1, 4))
                        add_op(FN_POP_INT, $urandom);
            endcase
            n_rand += ops_to_send.size() - k;
        end
        n_ops = ops_to_send.size();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_ops || want_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (want_beats.size() != 0)
            report_mismatch("expected beats left over", M_TDATA_W'(want_beats.size()), '0);

        $display("%0d operations in, %0d result beats checked, longest element run %0d",
                 n_taken, n_beats, longest_run);
        $display("%0d underflow and %0d overflow results, %0d mismatches",
                 n_under, n_over, err_cnt);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
